// ===== rtl/gthc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gthc_pkg
// Shared types, codes and constants of the go-to-pose heading controller.
// ----------------------------------------------------------------------------
package gthc_pkg;

    localparam int XY_W       = 36;
    localparam int ADDR_W     = 5;
    localparam int ATAN_DEPTH = 24;

    // reciprocal of five for magnitudes below 2^18
    localparam logic [16:0] DIV5_RECIP = 17'd52429;
    localparam int          DIV5_SHIFT = 18;

    localparam logic [31:0] RST_GOAL_X         = 32'd0;
    localparam logic [31:0] RST_GOAL_Y         = 32'd0;
    localparam logic [15:0] RST_GOAL_HEADING   = 16'd0;
    localparam logic [14:0] RST_ALIGN_TOL      = 15'd104;
    localparam logic [14:0] RST_FINAL_TOL      = 15'd52;
    localparam logic [15:0] RST_DIST_TOL       = 16'd655;
    localparam logic [31:0] RST_DIST_TOL_SQ    = 32'd429025;
    localparam logic [15:0] RST_FORWARD_SPEED  = 16'd6554;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_TICK   = 2'd1,
        OP_CANCEL = 2'd2,
        OP_HOLD   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PHASE_IDLE     = 2'd0,
        PHASE_APPROACH = 2'd1,
        PHASE_FINAL    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        REG_GOAL_X        = 3'd0,
        REG_GOAL_Y        = 3'd1,
        REG_GOAL_HEADING  = 3'd2,
        REG_ALIGN_TOL     = 3'd3,
        REG_FINAL_TOL     = 3'd4,
        REG_DIST_TOL      = 3'd5,
        REG_FORWARD_SPEED = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic [15:0]        goal_heading;
        logic [14:0]        align_tol;
        logic [14:0]        final_tol;
        logic [15:0]        dist_tol;
        logic [31:0]        dist_tol_sq;
        logic [15:0]        forward_speed;
    } cfg_t;

    typedef struct packed {
        op_t                  op;
        logic [15:0]          yaw;
        logic                 zero;
        logic                 near_lt;
        logic                 near;
        logic [31:0]          sq_x;
        logic [31:0]          sq_y;
        logic [32:0]          adx;
        logic [32:0]          ady;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [31:0]          z;
    } cstage_t;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/gthc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gthc_cfg
// APB register file holding the goal, tolerances and forward speed.
// ----------------------------------------------------------------------------
module gthc_cfg
    import gthc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [31:0] goal_x_reg;
    logic [31:0] goal_y_reg;
    logic [15:0] goal_heading_reg;
    logic [14:0] align_tol_reg;
    logic [14:0] final_tol_reg;
    logic [15:0] dist_tol_reg;
    logic [31:0] dist_tol_sq_reg;
    logic [15:0] forward_speed_reg;
    logic [31:0] dist_tol_sq_next;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    assign dist_tol_sq_next = 32'(dist_tol_reg) * 32'(dist_tol_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg        <= RST_GOAL_X;
            goal_y_reg        <= RST_GOAL_Y;
            goal_heading_reg  <= RST_GOAL_HEADING;
            align_tol_reg     <= RST_ALIGN_TOL;
            final_tol_reg     <= RST_FINAL_TOL;
            dist_tol_reg      <= RST_DIST_TOL;
            dist_tol_sq_reg   <= RST_DIST_TOL_SQ;
            forward_speed_reg <= RST_FORWARD_SPEED;
        end
        else
        begin
            dist_tol_sq_reg <= dist_tol_sq_next;
            if (wr_en)
            begin
                case (idx)
                    REG_GOAL_X:        goal_x_reg        <= pwdata;
                    REG_GOAL_Y:        goal_y_reg        <= pwdata;
                    REG_GOAL_HEADING:  goal_heading_reg  <= pwdata[15:0];
                    REG_ALIGN_TOL:     align_tol_reg     <= pwdata[14:0];
                    REG_FINAL_TOL:     final_tol_reg     <= pwdata[14:0];
                    REG_DIST_TOL:      dist_tol_reg      <= pwdata[15:0];
                    REG_FORWARD_SPEED: forward_speed_reg <= pwdata[15:0];
                    default:           ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (idx)
            REG_GOAL_X:        prdata = goal_x_reg;
            REG_GOAL_Y:        prdata = goal_y_reg;
            REG_GOAL_HEADING:  prdata = {16'd0, goal_heading_reg};
            REG_ALIGN_TOL:     prdata = {17'd0, align_tol_reg};
            REG_FINAL_TOL:     prdata = {17'd0, final_tol_reg};
            REG_DIST_TOL:      prdata = {16'd0, dist_tol_reg};
            REG_FORWARD_SPEED: prdata = {16'd0, forward_speed_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        cfg.goal_x        = goal_x_reg;
        cfg.goal_y        = goal_y_reg;
        cfg.goal_heading  = goal_heading_reg;
        cfg.align_tol     = align_tol_reg;
        cfg.final_tol     = final_tol_reg;
        cfg.dist_tol      = dist_tol_reg;
        cfg.dist_tol_sq   = dist_tol_sq_reg;
        cfg.forward_speed = forward_speed_reg;
    end

endmodule

// ===== rtl/gthc_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gthc_prep
// Input register, goal offset and vectoring start values with magnitudes.
// ----------------------------------------------------------------------------
module gthc_prep
    import gthc_pkg::*;
(
    input  logic               clk,
    input  logic [2:0]         load,
    input  cfg_t               cfg,
    input  logic [1:0]         operation,
    input  logic signed [31:0] pose_x,
    input  logic signed [31:0] pose_y,
    input  logic [15:0]        pose_yaw,
    output cstage_t            first
);

    op_t         op_reg;
    logic [31:0] px_reg;
    logic [31:0] py_reg;
    logic [15:0] yaw_reg;

    op_t         p1_op_reg;
    logic [15:0] p1_yaw_reg;
    logic [32:0] dx_reg;
    logic [32:0] dy_reg;
    logic        p1_zero_reg;
    logic [32:0] dx_next;
    logic [32:0] dy_next;
    logic        zero_next;

    cstage_t     p2_reg;
    cstage_t     p2_next;
    logic signed [XY_W-1:0] dx_ext;
    logic signed [XY_W-1:0] dy_ext;

    // input register
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            op_reg  <= op_t'(operation);
            px_reg  <= pose_x;
            py_reg  <= pose_y;
            yaw_reg <= pose_yaw;
        end
    end

    // offset to goal
    assign dx_next   = {cfg.goal_x[31], cfg.goal_x} - {px_reg[31], px_reg};
    assign dy_next   = {cfg.goal_y[31], cfg.goal_y} - {py_reg[31], py_reg};
    assign zero_next = (cfg.goal_x == px_reg) && (cfg.goal_y == py_reg);

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            p1_op_reg   <= op_reg;
            p1_yaw_reg  <= yaw_reg;
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            p1_zero_reg <= zero_next;
        end
    end

    // fold into the right half plane
    assign dx_ext = {{(XY_W-33){dx_reg[32]}}, dx_reg};
    assign dy_ext = {{(XY_W-33){dy_reg[32]}}, dy_reg};

    always_comb
    begin
        p2_next         = '0;
        p2_next.op      = p1_op_reg;
        p2_next.yaw     = p1_yaw_reg;
        p2_next.zero    = p1_zero_reg;
        p2_next.adx     = dx_reg[32] ? (33'd0 - dx_reg) : dx_reg;
        p2_next.ady     = dy_reg[32] ? (33'd0 - dy_reg) : dy_reg;
        if (dx_reg[32])
        begin
            p2_next.x = -dx_ext;
            p2_next.y = -dy_ext;
            p2_next.z = 32'h80000000;
        end
        else
        begin
            p2_next.x = dx_ext;
            p2_next.y = dy_ext;
            p2_next.z = 32'h00000000;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            p2_reg <= p2_next;
        end
    end

    assign first = p2_reg;

endmodule

// ===== rtl/gthc_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gthc_cordic
// Pipelined vectoring rotator for the bearing, one register per step;
// the arrival test rides along in the first two steps.
// ----------------------------------------------------------------------------
module gthc_cordic
    import gthc_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  logic              clk,
    input  logic [STAGES-1:0] load,
    input  cfg_t              cfg,
    input  cstage_t           first,
    output cstage_t           last
);

    cstage_t stage_reg  [STAGES];
    cstage_t stage_next [STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        cstage_t                cur;
        logic signed [XY_W-1:0] xc;
        logic signed [XY_W-1:0] yc;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        logic                   y_pos;
        logic [31:0]            sq_x_w;
        logic [31:0]            sq_y_w;

        if (i == 0)
        begin : g_head
            assign cur = first;
        end
        else
        begin : g_body
            assign cur = stage_reg[i-1];
        end

        assign xc     = cur.x;
        assign yc     = cur.y;
        assign xs     = xc >>> i;
        assign ys     = yc >>> i;
        assign y_pos  = !yc[XY_W-1] && (yc != '0);
        assign sq_x_w = 32'(cur.adx[15:0]) * 32'(cur.adx[15:0]);
        assign sq_y_w = 32'(cur.ady[15:0]) * 32'(cur.ady[15:0]);

        always_comb
        begin
            stage_next[i] = cur;
            if (y_pos)
            begin
                stage_next[i].x = xc + ys;
                stage_next[i].y = yc - xs;
                stage_next[i].z = cur.z + atan_entry(5'(i));
            end
            else
            begin
                stage_next[i].x = xc - ys;
                stage_next[i].y = yc + xs;
                stage_next[i].z = cur.z - atan_entry(5'(i));
            end
            // distance test: magnitudes and squares, then the sum
            if (i == 0)
            begin
                stage_next[i].near_lt = (cur.adx < {17'd0, cfg.dist_tol}) &&
                                        (cur.ady < {17'd0, cfg.dist_tol});
                stage_next[i].sq_x    = sq_x_w;
                stage_next[i].sq_y    = sq_y_w;
            end
            if (i == 1)
            begin
                stage_next[i].near = cur.near_lt &&
                    (({1'b0, cur.sq_x} + {1'b0, cur.sq_y}) < {1'b0, cfg.dist_tol_sq});
            end
        end

        always_ff @(posedge clk)
        begin
            if (load[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign last = stage_reg[STAGES-1];

endmodule

// ===== rtl/gthc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gthc_ctrl
// Bearing rounding, heading errors and gains, goal state flags and the
// result register.
// ----------------------------------------------------------------------------
module gthc_ctrl
    import gthc_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         load,
    input  logic               take,
    input  cfg_t               cfg,
    input  cstage_t            last,
    output logic [15:0]        linear_speed,
    output logic signed [15:0] angular_rate,
    output logic [1:0]         phase,
    output logic               goal_done,
    output logic               goal_canceled
);

    localparam int AW = ANGLE_WIDTH;

    // bearing rounding
    logic [32:0]   zsum;
    logic [AW-1:0] za;
    logic [15:0]   bearing;
    logic [15:0]   ferr_w;

    assign zsum = {1'b0, last.z} + (33'd1 << (31 - AW));
    assign za   = zsum[31 -: AW];

    if (AW > 16)
    begin : g_wide
        logic [AW:0] rsum;
        assign rsum    = {1'b0, za} + ({{AW{1'b0}}, 1'b1} << (AW - 17));
        assign bearing = rsum[AW-16 +: 16];
    end
    else if (AW < 16)
    begin : g_narrow
        assign bearing = {za, {(16-AW){1'b0}}};
    end
    else
    begin : g_equal
        assign bearing = za;
    end

    assign ferr_w = cfg.goal_heading - last.yaw;

    op_t         r_op_reg;
    logic        r_near_reg;
    logic [15:0] r_bearing_reg;
    logic [15:0] r_yaw_reg;
    logic        r_ferr_neg_reg;
    logic [16:0] r_aferr_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            r_op_reg       <= last.op;
            r_near_reg     <= last.near;
            r_bearing_reg  <= last.zero ? 16'd0 : bearing;
            r_yaw_reg      <= last.yaw;
            r_ferr_neg_reg <= ferr_w[15];
            r_aferr_reg    <= ferr_w[15] ? (17'h10000 - {1'b0, ferr_w}) : {1'b0, ferr_w};
        end
    end

    // bearing error, half gain and two-fifths gain
    logic [15:0] err_w;
    logic [16:0] aerr_w;
    logic [16:0] hsum;
    logic [34:0] prod;
    logic [15:0] q16;

    assign err_w  = r_bearing_reg - r_yaw_reg;
    assign aerr_w = err_w[15] ? (17'h10000 - {1'b0, err_w}) : {1'b0, err_w};
    assign hsum   = {err_w[15], err_w} + {16'd0, err_w[15]};
    assign prod   = 35'({r_aferr_reg, 1'b0}) * 35'(DIV5_RECIP);
    assign q16    = prod[DIV5_SHIFT +: 16];

    op_t         e_op_reg;
    logic        e_near_reg;
    logic        e_align_hit_reg;
    logic        e_final_hit_reg;
    logic [15:0] e_half_reg;
    logic [15:0] e_fang_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            e_op_reg        <= r_op_reg;
            e_near_reg      <= r_near_reg;
            e_align_hit_reg <= aerr_w < {2'd0, cfg.align_tol};
            e_final_hit_reg <= r_aferr_reg < {2'd0, cfg.final_tol};
            e_half_reg      <= hsum[16:1];
            e_fang_reg      <= r_ferr_neg_reg ? (16'd0 - q16) : q16;
        end
    end

    // goal state
    logic   active_reg;
    logic   drive_latched_reg;
    logic   final_turn_reg;
    logic   speed_on_reg;
    logic   active_next;
    logic   drive_latched_next;
    logic   final_turn_next;
    logic   speed_on_next;

    logic [15:0] lin_next;
    logic [15:0] ang_next;
    phase_t      phase_next;
    logic        done_next;
    logic        canceled_next;

    logic [15:0] lin_reg;
    logic [15:0] ang_reg;
    phase_t      phase_reg;
    logic        done_reg;
    logic        canceled_reg;

    always_comb
    begin
        active_next        = active_reg;
        drive_latched_next = drive_latched_reg;
        final_turn_next    = final_turn_reg;
        speed_on_next      = speed_on_reg;
        lin_next           = 16'd0;
        ang_next           = 16'd0;
        phase_next         = PHASE_IDLE;
        done_next          = 1'b0;
        canceled_next      = 1'b0;
        case (e_op_reg)
            OP_START:
            begin
                active_next        = 1'b1;
                drive_latched_next = 1'b0;
                final_turn_next    = 1'b0;
                speed_on_next      = 1'b0;
                phase_next         = PHASE_APPROACH;
            end
            OP_TICK:
            begin
                if (active_reg)
                begin
                    drive_latched_next = drive_latched_reg | e_align_hit_reg;
                    ang_next           = e_align_hit_reg ? 16'd0 : e_half_reg;
                    speed_on_next      = speed_on_reg | drive_latched_next;
                    if (e_near_reg)
                    begin
                        drive_latched_next = 1'b0;
                        final_turn_next    = 1'b1;
                        speed_on_next      = 1'b0;
                    end
                    phase_next = PHASE_APPROACH;
                    if (final_turn_next)
                    begin
                        phase_next = PHASE_FINAL;
                        if (e_final_hit_reg)
                        begin
                            active_next        = 1'b0;
                            drive_latched_next = 1'b0;
                            final_turn_next    = 1'b0;
                            speed_on_next      = 1'b0;
                            ang_next           = 16'd0;
                            phase_next         = PHASE_IDLE;
                            done_next          = 1'b1;
                        end
                        else
                        begin
                            ang_next = e_fang_reg;
                        end
                    end
                    lin_next = speed_on_next ? cfg.forward_speed : 16'd0;
                end
            end
            OP_CANCEL:
            begin
                canceled_next      = active_reg;
                active_next        = 1'b0;
                drive_latched_next = 1'b0;
                final_turn_next    = 1'b0;
                speed_on_next      = 1'b0;
            end
            OP_HOLD:
            begin
                if (active_reg)
                begin
                    phase_next = final_turn_reg ? PHASE_FINAL : PHASE_APPROACH;
                end
            end
            default:
            begin
                phase_next = PHASE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg        <= 1'b0;
            drive_latched_reg <= 1'b0;
            final_turn_reg    <= 1'b0;
            speed_on_reg      <= 1'b0;
        end
        else if (take)
        begin
            active_reg        <= active_next;
            drive_latched_reg <= drive_latched_next;
            final_turn_reg    <= final_turn_next;
            speed_on_reg      <= speed_on_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            lin_reg      <= lin_next;
            ang_reg      <= ang_next;
            phase_reg    <= phase_next;
            done_reg     <= done_next;
            canceled_reg <= canceled_next;
        end
    end

    assign linear_speed  = lin_reg;
    assign angular_rate  = ang_reg;
    assign phase         = phase_reg;
    assign goal_done     = done_reg;
    assign goal_canceled = canceled_reg;

endmodule

// ===== rtl/go_to_pose_heading_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_pose_heading_controller
// Proportional go-to-goal controller: start, pose tick, hold and cancel
// requests in, one speed and turn rate command out per request.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_stall is low and returns one result
// per request, in order. A request passes through an input register, two
// offset stages, one register per bearing rotation step, two error stages
// and the result register. Each stage holds its item while the stage after
// it is full and cannot move on, so requests keep flowing into empty stages
// while a result waits on out_stall. Goal state is updated when a request
// reaches the result register. Registers come up with align tolerance 104,
// final tolerance 52, arrival radius 655 and forward speed 6554, goal at the
// origin with heading zero.
// ----------------------------------------------------------------------------
module go_to_pose_heading_controller
    import gthc_pkg::*;
#(
    parameter int ANGLE_WIDTH      = 16,
    parameter int VECTORING_STAGES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic signed [31:0] pose_x,
    input  logic signed [31:0] pose_y,
    input  logic [15:0]        pose_yaw,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        linear_speed,
    output logic signed [15:0] angular_rate,
    output logic [1:0]         phase,
    output logic               goal_done,
    output logic               goal_canceled,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int DEPTH  = VECTORING_STAGES + 6;
    localparam int C_LO   = 3;
    localparam int C_HI   = C_LO + VECTORING_STAGES - 1;
    localparam int E_IDX  = DEPTH - 2;
    localparam int O_IDX  = DEPTH - 1;

    cfg_t              cfg;
    cstage_t           first;
    cstage_t           last;
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;
    logic [DEPTH:0]    ready;
    logic              take;

    // per-stage flow control
    assign ready[DEPTH] = !out_stall;
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_ready
        assign ready[i] = !valid_reg[i] || ready[i+1];
    end

    always_comb
    begin
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[O_IDX];
    assign take      = ready[O_IDX] && valid_reg[E_IDX];

    gthc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gthc_prep u_prep (
        .clk       (clk),
        .load      (ready[2:0]),
        .cfg       (cfg),
        .operation (operation),
        .pose_x    (pose_x),
        .pose_y    (pose_y),
        .pose_yaw  (pose_yaw),
        .first     (first)
    );

    gthc_cordic #(
        .STAGES (VECTORING_STAGES)
    ) u_cordic (
        .clk   (clk),
        .load  (ready[C_HI:C_LO]),
        .cfg   (cfg),
        .first (first),
        .last  (last)
    );

    gthc_ctrl #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (ready[O_IDX:C_HI+1]),
        .take          (take),
        .cfg           (cfg),
        .last          (last),
        .linear_speed  (linear_speed),
        .angular_rate  (angular_rate),
        .phase         (phase),
        .goal_done     (goal_done),
        .goal_canceled (goal_canceled)
    );

endmodule
